FILE: src/sskv_pkg.sv
// shared constants, types and codes of the sorted sparse key/value table
package sskv_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W    = 3;
    localparam int KEY_W   = 31;
    localparam int VAL_W   = 32;
    localparam int RANK_W  = 6;
    localparam int OCNT_W  = 7;
    localparam int ST_W    = 2;
    localparam int CMP_W   = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    typedef enum logic [OP_W-1:0] {
        OP_ACCESS   = 3'd0,
        OP_WRITE    = 3'd1,
        OP_CONTAINS = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_RANK     = 3'd4
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_RANK = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                cmp_en;
        logic                upd_en;
        logic                rank_op;
        logic                insert;
        logic                write_hit;
        logic [KEY_W-1:0]    key;
        logic signed [VAL_W-1:0] value;
        logic [RANK_W-1:0]   rank;
        logic [CNT_W-1:0]    occupancy;
    } t_cell_cmd;

    // handed from one cell to its right neighbour
    typedef struct packed {
        logic                    after;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_cell_link;

endpackage

FILE: src/sskv_if.sv
// request and response channel interfaces

interface sskv_req_if;
    logic                                valid;
    logic                                ready;
    logic [sskv_pkg::OP_W-1:0]           opcode;
    logic [sskv_pkg::KEY_W-1:0]          key;
    logic signed [sskv_pkg::VAL_W-1:0]   value;
    logic [sskv_pkg::RANK_W-1:0]         rank;

    modport source (output valid, opcode, key, value, rank, input ready);
    modport sink   (input valid, opcode, key, value, rank, output ready);
endinterface

interface sskv_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [sskv_pkg::VAL_W-1:0]   value_out;
    logic [sskv_pkg::KEY_W-1:0]          key_out;
    logic                                found;
    logic [sskv_pkg::OCNT_W-1:0]         entry_count;
    logic [sskv_pkg::ST_W-1:0]           status;

    modport source (output valid, value_out, key_out, found, entry_count, status,
                    input ready);
    modport sink   (input valid, value_out, key_out, found, entry_count, status,
                    output ready);
endinterface

FILE: src/sskv_cell.sv
// one table slot: holds a pair, compares against the request and shifts right on insert
module sskv_cell (
    input  logic                                i_clk,
    input  logic [sskv_pkg::IDX_W-1:0]          i_idx,
    input  sskv_pkg::t_cell_cmd                 i_cmd,
    input  sskv_pkg::t_cell_link                i_left,
    output sskv_pkg::t_cell_link                o_link,
    output logic                                o_sel,
    output logic [sskv_pkg::KEY_W-1:0]          o_sel_key,
    output logic signed [sskv_pkg::VAL_W-1:0]   o_sel_value
);

    logic [sskv_pkg::KEY_W-1:0]          r_key;
    logic signed [sskv_pkg::VAL_W-1:0]   r_value;
    logic                                r_after;
    logic                                r_sel;
    logic                                in_use;
    logic                                n_after;
    logic                                n_sel;

    assign in_use = sskv_pkg::CNT_W'(i_idx) < i_cmd.occupancy;

    always_comb begin
        // set for every slot whose key is not below the request, and for every free slot
        n_after = !in_use || (r_key >= i_cmd.key);
        if (i_cmd.rank_op) begin
            n_sel = in_use &&
                (sskv_pkg::CMP_W'(i_idx) == sskv_pkg::CMP_W'(i_cmd.rank));
        end else begin
            n_sel = in_use && (r_key == i_cmd.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_after <= n_after;
            r_sel   <= n_sel;
        end
        if (i_cmd.upd_en) begin
            if (i_cmd.insert && r_after) begin
                if (i_left.after) begin
                    r_key   <= i_left.key;
                    r_value <= i_left.value;
                end else begin
                    r_key   <= i_cmd.key;
                    r_value <= i_cmd.value;
                end
            end else if (i_cmd.write_hit && r_sel) begin
                r_value <= i_cmd.value;
            end
        end
    end

    assign o_link.after = r_after;
    assign o_link.key   = r_key;
    assign o_link.value = r_value;
    assign o_sel        = r_sel;
    assign o_sel_key    = r_sel ? r_key : '0;
    assign o_sel_value  = r_sel ? r_value : '0;

endmodule

FILE: src/sorted_sparse_key_value_table.sv
// top level: request control, result register and the chain of table cells

// A sorted key/value table of sskv_pkg::CAPACITY pairs held in a row of cells, one pair per
// cell, in ascending key order. The request is registered on the accepting edge, and its
// response is valid after the compare state S_CMP, in which every cell compares its key (or its
// position, for read at rank) in parallel, and the update state S_UPD, in which the matching cell
// is read out through an OR tree and, on insert, every cell at or after the insertion point takes
// the pair of its left neighbour while the slot itself loads the new key. Requests are taken one
// at a time; the next is accepted once the previous response has been placed in the output
// register, even while that response is still waiting to be taken. A response that cannot be
// placed because the output register still holds an untaken word stalls the table for as long
// as the sink holds off. Opcodes: access returns the value and inserts an absent key with zero,
// write inserts if needed and stores the value, contains looks up without inserting, clear
// empties the table, read at rank returns the pair at a sorted position. A full table refuses
// inserts with status 1; a rank past the stored entries gives status 2. No clearing pass is
// needed after reset.
module sorted_sparse_key_value_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sskv_req_if.sink   i_req,
    sskv_rsp_if.source o_rsp
);

    localparam int N = sskv_pkg::CAPACITY;

    sskv_pkg::t_state                    r_state, n_state;

    // latched request
    logic [sskv_pkg::OP_W-1:0]           r_op;
    logic [sskv_pkg::KEY_W-1:0]          r_key;
    logic signed [sskv_pkg::VAL_W-1:0]   r_val;
    logic [sskv_pkg::RANK_W-1:0]         r_rank;

    logic [sskv_pkg::CNT_W-1:0]          r_occ, n_occ;

    // output word register
    logic                                r_out_valid;
    logic signed [sskv_pkg::VAL_W-1:0]   r_out_value;
    logic [sskv_pkg::KEY_W-1:0]          r_out_key;
    logic                                r_out_found;
    logic [sskv_pkg::OCNT_W-1:0]         r_out_count;
    logic [sskv_pkg::ST_W-1:0]           r_out_status;

    logic                                accept;
    logic                                finish;

    // cell chain
    sskv_pkg::t_cell_cmd                 cmd;
    sskv_pkg::t_cell_link                link [N+1];
    logic [N-1:0]                        sel;
    logic [sskv_pkg::KEY_W-1:0]          sel_key [N];
    logic signed [sskv_pkg::VAL_W-1:0]   sel_value [N];

    // gathered results
    logic [sskv_pkg::KEY_W-1:0]          hit_key;
    logic signed [sskv_pkg::VAL_W-1:0]   hit_value;
    logic                                hit;
    logic                                key_op;
    logic                                is_write;
    logic                                need_insert;
    logic                                full;
    logic                                do_insert;

    logic signed [sskv_pkg::VAL_W-1:0]   n_out_value;
    logic [sskv_pkg::KEY_W-1:0]          n_out_key;
    logic                                n_out_found;
    logic [sskv_pkg::ST_W-1:0]           n_out_status;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == sskv_pkg::S_IDLE);

    // response can be loaded when the output register is free or being drained
    assign finish = (r_state == sskv_pkg::S_UPD) && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sskv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sskv_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = sskv_pkg::S_CMP;
                end
            end
            sskv_pkg::S_CMP: begin
                n_state = sskv_pkg::S_UPD;
            end
            sskv_pkg::S_UPD: begin
                if (finish) begin
                    n_state = sskv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sskv_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.opcode;
            r_key  <= i_req.key;
            r_val  <= i_req.value;
            r_rank <= i_req.rank;
        end
    end

    // opcode decode
    always_comb begin
        key_op   = 1'b0;
        is_write = 1'b0;
        case (r_op)
            sskv_pkg::OP_ACCESS:   key_op = 1'b1;
            sskv_pkg::OP_CONTAINS: key_op = 1'b1;
            sskv_pkg::OP_WRITE: begin
                key_op   = 1'b1;
                is_write = 1'b1;
            end
            default: begin
                key_op   = 1'b0;
                is_write = 1'b0;
            end
        endcase
    end

    // one-hot select from the cells, folded with an or tree
    always_comb begin
        hit_key   = '0;
        hit_value = '0;
        for (int i = 0; i < N; i++) begin
            hit_key   = hit_key | sel_key[i];
            hit_value = hit_value | sel_value[i];
        end
        hit = |sel;
    end

    assign need_insert = key_op && (r_op != sskv_pkg::OP_CONTAINS) && !hit;
    assign full        = need_insert && (r_occ == sskv_pkg::CNT_W'(N));
    assign do_insert   = need_insert && !full;

    always_comb begin
        n_occ        = r_occ;
        n_out_value  = '0;
        n_out_key    = r_key;
        n_out_found  = 1'b0;
        n_out_status = sskv_pkg::ST_OK;
        case (r_op)
            sskv_pkg::OP_ACCESS, sskv_pkg::OP_WRITE, sskv_pkg::OP_CONTAINS: begin
                n_out_found = hit;
                if (hit) begin
                    n_out_value = is_write ? r_val : hit_value;
                end else if (do_insert) begin
                    n_out_value = is_write ? r_val : '0;
                    n_occ       = r_occ + 1'b1;
                end else if (full) begin
                    n_out_status = sskv_pkg::ST_FULL;
                end
            end
            sskv_pkg::OP_CLEAR: begin
                n_occ = '0;
            end
            sskv_pkg::OP_RANK: begin
                n_out_key   = hit_key;
                n_out_value = hit_value;
                n_out_found = hit;
                if (!hit) begin
                    n_out_status = sskv_pkg::ST_RANK;
                end
            end
            default: begin
                n_occ = r_occ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (finish) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_value  <= n_out_value;
            r_out_key    <= n_out_key;
            r_out_found  <= n_out_found;
            r_out_count  <= sskv_pkg::OCNT_W'(n_occ);
            r_out_status <= n_out_status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.value_out   = r_out_value;
    assign o_rsp.key_out     = r_out_key;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.status      = r_out_status;

    // command broadcast to the row of cells
    always_comb begin
        cmd.cmp_en    = (r_state == sskv_pkg::S_CMP);
        cmd.upd_en    = finish;
        cmd.rank_op   = (r_op == sskv_pkg::OP_RANK);
        cmd.insert    = do_insert;
        cmd.write_hit = is_write && hit;
        cmd.key       = r_key;
        // value loaded by a write, or by a fresh insert
        cmd.value     = is_write ? r_val : '0;
        cmd.rank      = r_rank;
        cmd.occupancy = r_occ;
    end

    // left edge of the chain: nothing to shift in
    assign link[0].after = 1'b0;
    assign link[0].key   = '0;
    assign link[0].value = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        sskv_cell u_cell (
            .i_clk       (i_clk),
            .i_idx       (sskv_pkg::IDX_W'(g)),
            .i_cmd       (cmd),
            .i_left      (link[g]),
            .o_link      (link[g+1]),
            .o_sel       (sel[g]),
            .o_sel_key   (sel_key[g]),
            .o_sel_value (sel_value[g])
        );
    end

endmodule

FILE: dv/sorted_sparse_key_value_table_tb.sv
// self-checking testbench of the sorted sparse key/value table against a mirror of its contents
import sskv_pkg::*;

typedef struct {
    logic signed [VAL_W-1:0] value_out;
    logic [KEY_W-1:0]        key_out;
    logic                    found;
    logic [OCNT_W-1:0]       entry_count;
    logic [ST_W-1:0]         status;
} kv_reply_t;

// mirror of the sorted table, with the replies it still owes
class kv_table_mirror;
    logic [KEY_W-1:0]        keys [CAPACITY];
    logic signed [VAL_W-1:0] vals [CAPACITY];
    int                      count;
    kv_reply_t               owed_replies [$];
    int                      mismatches;

    function new();
        count = 0;
        mismatches = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic signed [VAL_W-1:0] value, logic [RANK_W-1:0] rank);
        kv_reply_t r;
        int        pos;
        bit        hit;
        r.value_out = '0;
        r.key_out   = key;
        r.found     = 1'b0;
        r.status    = ST_OK;
        case (op)
            OP_ACCESS, OP_WRITE, OP_CONTAINS: begin
                // first slot whose key is not below the request key
                pos = count;
                for (int i = count - 1; i >= 0; i--) begin
                    if (keys[i] >= key)
                        pos = i;
                end
                hit = (pos < count) && (keys[pos] == key);
                if (hit) begin
                    r.found = 1'b1;
                    if (op == OP_WRITE)
                        vals[pos] = value;
                    r.value_out = vals[pos];
                end else if (op != OP_CONTAINS) begin
                    if (count >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int j = count; j > pos; j--) begin
                            keys[j] = keys[j-1];
                            vals[j] = vals[j-1];
                        end
                        keys[pos] = key;
                        vals[pos] = (op == OP_WRITE) ? value : '0;
                        count++;
                        r.value_out = vals[pos];
                    end
                end
            end
            OP_CLEAR: begin
                count = 0;
            end
            OP_RANK: begin
                r.key_out = '0;
                if (rank < count) begin
                    r.key_out   = keys[rank];
                    r.value_out = vals[rank];
                    r.found     = 1'b1;
                end else begin
                    r.status = ST_RANK;
                end
            end
            default: ;
        endcase
        r.entry_count = OCNT_W'(count);
        owed_replies.push_back(r);
    endfunction

    function void field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_reply(kv_reply_t got);
        kv_reply_t want;
        if (owed_replies.size() == 0) begin
            $display("%0t: unexpected word, expected none, got value_out %h key_out %h",
                     $time, got.value_out, got.key_out);
            mismatches++;
            return;
        end
        want = owed_replies.pop_front();
        field_differs("value_out", want.value_out, got.value_out);
        field_differs("key_out", want.key_out, got.key_out);
        field_differs("found", want.found, got.found);
        field_differs("entry_count", want.entry_count, got.entry_count);
        field_differs("status", want.status, got.status);
    endfunction

    function int outstanding();
        return owed_replies.size();
    endfunction
endclass

module sorted_sparse_key_value_table_tb;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 450;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_OFF     = 400;
    localparam int HOLD_OFF_AT  = 120;
    localparam int DRAIN_CYCLES = 10;
    localparam int FILL_KEYS    = CAPACITY + 2;

    localparam logic [KEY_W-1:0]        KEY_MAX  = '1;
    localparam logic [RANK_W-1:0]       RANK_MAX = '1;
    localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_ONES = '1;
    localparam logic [OP_W-1:0]         OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0]         OP_UNUSED_LAST  = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sskv_req_if req_if();
    sskv_rsp_if rsp_if();

    kv_table_mirror table_mirror = new();

    logic [KEY_W-1:0] key_pool [FILL_KEYS];
    int               pool_size     = 0;
    int               words_sent    = 0;
    int               replies_taken = 0;
    int               idle_cycles   = 0;
    int               send_calm     = 0;
    int               recv_calm     = 0;
    kv_reply_t        seen;

    sorted_sparse_key_value_table uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #HALF_PERIOD clk = ~clk;

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            calm_left = 40;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 24)
            return OP_ACCESS;
        if (r < 54)
            return OP_WRITE;
        if (r < 72)
            return OP_CONTAINS;
        if (r < 94)
            return OP_RANK;
        if (r < 96)
            return OP_CLEAR;
        return OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        if ($urandom_range(0, 1) != 0)
            return KEY_W'($urandom);
        return KEY_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (pool_size > 0 && r < 80)
            return key_pool[$urandom_range(0, pool_size - 1)];
        if (r < 88) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return KEY_W'(1);
                2:       return KEY_MAX - 1;
                default: return KEY_MAX;
            endcase
        end
        return KEY_W'($urandom);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 85)
            return VAL_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return VAL_ONES;
            2:       return VAL_MAX;
            default: return VAL_MIN;
        endcase
    endfunction

    function automatic logic [RANK_W-1:0] pick_rank();
        if ($urandom_range(0, 1) != 0)
            return RANK_W'($urandom_range(0, 63));
        return RANK_W'($urandom_range(0, 7));
    endfunction

    // one request word, after a random gap; valid stays up between back-to-back words
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic signed [VAL_W-1:0] value,
                                input logic [RANK_W-1:0] rank);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.key    <= key;
        req_if.value  <= value;
        req_if.rank   <= rank;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
        words_sent++;
    endtask

    // fill the table past capacity in random order, then work on the full table
    task automatic run_fill_segment();
        logic [KEY_W-1:0] k;
        bit               dup;
        send_request(OP_CLEAR, fresh_key(), pick_value(), pick_rank());
        pool_size = 0;
        while (pool_size < FILL_KEYS) begin
            k = fresh_key();
            dup = 1'b0;
            for (int i = 0; i < pool_size; i++) begin
                if (key_pool[i] == k)
                    dup = 1'b1;
            end
            if (!dup) begin
                key_pool[pool_size] = k;
                pool_size++;
            end
        end
        for (int i = 0; i < pool_size; i++)
            send_request(($urandom_range(0, 1) != 0) ? OP_WRITE : OP_ACCESS, key_pool[i],
                         pick_value(), pick_rank());
        repeat ($urandom_range(20, 60))
            send_request(pick_op(), pick_key(), pick_value(), pick_rank());
    endtask

    task automatic run_mixed_segment();
        if ($urandom_range(0, 2) != 0)
            send_request(OP_CLEAR, fresh_key(), pick_value(), pick_rank());
        pool_size = $urandom_range(1, 24);
        for (int i = 0; i < pool_size; i++)
            key_pool[i] = fresh_key();
        repeat ($urandom_range(25, 80))
            send_request(pick_op(), pick_key(), pick_value(), pick_rank());
    endtask

    initial begin : request_side
        int segment;
        req_if.valid  = 1'b0;
        req_if.opcode = OP_ACCESS;
        req_if.key    = '0;
        req_if.value  = '0;
        req_if.rank   = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, extremes, insert order, ranks, spare opcodes, clear
        send_request(OP_CLEAR, KEY_MAX, VAL_ONES, RANK_MAX);
        send_request(OP_CONTAINS, '0, VAL_MAX, '0);
        send_request(OP_RANK, KEY_MAX, '0, '0);
        send_request(OP_ACCESS, '0, VAL_ONES, RANK_MAX);
        send_request(OP_WRITE, KEY_MAX, VAL_MIN, '0);
        send_request(OP_WRITE, '0, VAL_MAX, '0);
        send_request(OP_ACCESS, '0, '0, '0);
        send_request(OP_CONTAINS, KEY_MAX, '0, '0);
        send_request(OP_WRITE, KEY_W'(1), VAL_ONES, '0);
        send_request(OP_ACCESS, KEY_MAX - 1, VAL_MAX, '0);
        send_request(OP_RANK, '0, '0, '0);
        send_request(OP_RANK, '0, '0, RANK_W'(3));
        send_request(OP_RANK, '0, '0, RANK_W'(4));
        send_request(OP_RANK, KEY_MAX, VAL_ONES, RANK_MAX);
        send_request(OP_CONTAINS, KEY_W'(2), '0, '0);
        for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
            send_request(OP_W'(c), KEY_MAX, VAL_ONES, RANK_MAX);
        send_request(OP_WRITE, KEY_W'(1), '0, '0);
        send_request(OP_CLEAR, '0, '0, '0);
        send_request(OP_RANK, '0, '0, '0);
        send_request(OP_ACCESS, KEY_MAX, '0, '0);
        send_request(OP_RANK, '0, '0, '0);

        // random: the first segment always fills the table
        words_sent = 0;
        segment = 0;
        while (words_sent < RANDOM_ITEMS) begin
            if (segment == 0 || $urandom_range(0, 3) == 0)
                run_fill_segment();
            else
                run_mixed_segment();
            segment++;
        end

        req_if.valid <= 1'b0;
        while (table_mirror.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_mirror.mismatches == 0)
            $display("sorted_sparse_key_value_table_tb: PASS");
        else
            $display("sorted_sparse_key_value_table_tb: FAIL");
        $finish;
    end

    initial begin : response_side
        int gap;
        bit held;
        held = 1'b0;
        rsp_if.ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            // one long hold-off so that the block backs up onto its input
            if (!held && replies_taken >= HOLD_OFF_AT) begin
                held = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
            end
            gap = pick_gap(recv_calm);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n && req_if.valid && req_if.ready)
            table_mirror.note_request(req_if.opcode, req_if.key, req_if.value, req_if.rank);
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            seen.value_out   = rsp_if.value_out;
            seen.key_out     = rsp_if.key_out;
            seen.found       = rsp_if.found;
            seen.entry_count = rsp_if.entry_count;
            seen.status      = rsp_if.status;
            table_mirror.check_reply(seen);
            replies_taken++;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("sorted_sparse_key_value_table_tb: FAIL");
            $finish;
        end
    end
endmodule

FILE: files.f
src/sskv_pkg.sv
src/sskv_if.sv
src/sskv_cell.sv
src/sorted_sparse_key_value_table.sv
dv/sorted_sparse_key_value_table_tb.sv
